>>> rtl/tftp_wts_pkg.sv
// shared types and constants of the windowed tftp transfer engine
package tftp_wts_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RTT,
    S_POST,
    S_FILL,
    S_SEND,
    S_DACK,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    K_DATA  = 3'd0,
    K_ACK   = 3'd1,
    K_ERROR = 3'd2,
    K_DONE  = 3'd3,
    K_ABORT = 3'd4,
    K_UNEXP = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SS_ACTIVE     = 2'd0,
    SS_FINISHED   = 2'd1,
    SS_PEER_ABORT = 2'd2,
    SS_ERR_ABORT  = 2'd3
  } status_t;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  localparam logic [2:0] CFG_DIRECTION  = 3'd0;
  localparam logic [2:0] CFG_WINDOW     = 3'd1;
  localparam logic [2:0] CFG_BLOCK_SIZE = 3'd2;
  localparam logic [2:0] CFG_FILE_BYTES = 3'd3;
  localparam logic [2:0] CFG_OACK       = 3'd4;
  localparam logic [2:0] CFG_RTT_IGNORE = 3'd5;

  localparam logic [2:0] ERR_ILLEGAL_OP = 3'd4;

  localparam int WRAP        = 65536;
  localparam int GUARD       = 32000;
  localparam int HDR_BYTES   = 4;
  localparam int BURST_LIMIT = 32;

endpackage

>>> rtl/tftp_windowed_transfer_step_top.sv
// windowed tftp transfer engine for one session
//
// usage
//   input channel (in_*): one transaction per received packet header
//   (opcode, 16-bit block, length, time in ms). in_ready is high only while
//   the engine is idle; one packet is worked on at a time.
//   result channel (out_*): zero or more result transactions per packet,
//   out_last marks the final one. results leave through one output register
//   that also holds the round-trip sums, so the engine takes the next packet
//   while the last result still waits.
//   cfg port: cfg_wr_en writes register cfg_index with cfg_data at once;
//   write only while idle. writing file_bytes reloads the remaining-bytes
//   counter, writing oack_pending reloads the option-ack flag.
// processing steps
//   for an ack while sending, from the accepting edge to the first result:
//   decode, optional round-trip update from the stamp memory (synchronous
//   read), window slide and fill check. a burst of data-send results then
//   leaves one per cycle while out_ready allows, up to 32, each writing its
//   send stamp into the stamp memory. the longest path is idle, decode,
//   round trip, slide, fill check and 32 sends.
// reset
//   synchronous, active low: session active, window at block 1, stamp
//   valid bits cleared so unwritten stamps read as zero. no clearing pass.
// back-pressure
//   while out_ready is low and a result is pending, the engine holds in
//   its send, data-ack or emit state; nothing is lost or repeated.
module tftp_windowed_transfer_step_top #(
  parameter int WINDOW_MAX = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_command,
  input  logic [15:0] in_block_low,
  input  logic [15:0] in_packet_length,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_block_number,
  output logic [15:0] out_byte_count,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_rtt_total,
  output logic [31:0] out_timed_packets,
  output logic        out_last
);
  import tftp_wts_pkg::*;

  // signed working width, wide enough for unwrapped blocks and 32-bit compares
  localparam int CB  = COUNT_BITS;
  localparam int SW  = ((CB > 32) ? CB : 32) + 2;
  localparam int SL  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SK  = $clog2(WINDOW_MAX) + 2;
  localparam logic [SL-1:0] UNA_SLOT0 = SL'(1 % WINDOW_MAX);
  localparam logic signed [SW-1:0] WRAP_X  = SW'(WRAP);
  localparam logic signed [SW-1:0] GUARD_X = SW'(GUARD);
  localparam logic signed [SW-1:0] WMAX_X  = SW'(WINDOW_MAX);
  localparam logic signed [SW-1:0] ONE_X   = SW'(1);
  localparam logic signed [SW-1:0] ZERO_X  = SW'(0);

  // configuration
  logic        direction_r;
  logic [5:0]  window_size_r;
  logic [15:0] block_size_r;
  logic [31:0] rtt_ign_r;

  // session state
  logic [CB-1:0] una_r, una_nxt;
  logic [CB-1:0] lsb_r, lsb_nxt;
  logic [SL-1:0] una_slot_r, una_slot_nxt;
  logic [SL-1:0] lsb_slot_r, lsb_slot_nxt;
  logic          oack_r, oack_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   bytes_left_r, bytes_left_nxt;
  logic [31:0]   rtt_sum_r, rtt_sum_nxt;
  logic [31:0]   timed_r, timed_nxt;
  status_t       status_r, status_nxt;
  state_t        state_r, state_nxt;
  logic [5:0]    sent_r, sent_nxt;

  // latched packet and working values
  logic [15:0] cmd_r, small_r, plen_r;
  logic [31:0] now_r;
  logic signed [SW-1:0] blk_r, blk_nxt;
  kind_t       e_kind_r, e_kind_nxt;
  logic [15:0] e_blk_r, e_blk_nxt;
  logic [2:0]  e_err_r, e_err_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [15:0] out_blk_r, out_blk_nxt;
  logic [15:0] out_bytes_r, out_bytes_nxt;
  logic [2:0]  out_err_r, out_err_nxt;
  logic [31:0] out_rtt_r, out_rtt_nxt;
  logic [31:0] out_timed_r, out_timed_nxt;
  logic        out_last_r, out_last_nxt;

  // send stamp memory with per-entry valid bits
  logic [31:0]           stamp_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] stamp_ok_r;
  logic [31:0]           rd_data_r;
  logic                  rd_ok_r;
  logic [SL-1:0]         rd_addr;
  logic                  wr_en;
  logic [SL-1:0]         wr_addr;

  function automatic logic [SL-1:0] slot_add(input logic [SL-1:0] s, input logic [SK-1:0] k);
    logic [SK:0] sum;
    sum = (SK+1)'(s) + (SK+1)'(k);
    if (sum >= (SK+1)'(WINDOW_MAX)) sum = sum - (SK+1)'(WINDOW_MAX);
    return sum[SL-1:0];
  endfunction

  // decode signals
  logic signed [SW-1:0] una_x, lsb_x, w_x, ign_x;
  logic signed [SW-1:0] ack_raw, ack_blk, data_raw, data_blk, nr, lsb_new_x;
  logic                 in_win, fin_ack, cond_oack, cond_fill, out_free;
  logic [CB-1:0]        lsb_new;
  logic [15:0]          len16, payload;
  logic                 done_new, cont, short_blk;
  logic [SK-1:0]        slide_k;

  always_comb begin
    una_x = $signed({{(SW-CB){1'b0}}, una_r});
    lsb_x = $signed({{(SW-CB){1'b0}}, lsb_r});
    ign_x = $signed({{(SW-32){1'b0}}, rtt_ign_r});
    if (window_size_r == 6'd0) w_x = ONE_X;
    else if ($signed({{(SW-6){1'b0}}, window_size_r}) > WMAX_X) w_x = WMAX_X;
    else w_x = $signed({{(SW-6){1'b0}}, window_size_r});
    // widen the ack block around first_unacked
    ack_raw  = $signed({{(SW-CB){1'b0}}, una_r[CB-1:16], small_r});
    ack_blk  = (ack_raw > una_x + GUARD_X) ? ack_raw - WRAP_X : ack_raw;
    // widen the data block around last block taken
    data_raw = $signed({{(SW-CB){1'b0}}, lsb_r[CB-1:16], small_r});
    data_blk = (data_raw < lsb_x - GUARD_X) ? data_raw + WRAP_X : data_raw;
    nr       = (blk_r < una_x) ? blk_r + WRAP_X : blk_r;
    in_win   = (una_x <= nr) && (nr < una_x + w_x) && (nr <= lsb_x);
    fin_ack  = (blk_r == una_x) && (blk_r == lsb_x) && done_r;
    slide_k  = SK'(nr - una_x) + SK'(1);
    cond_oack = (lsb_x - una_x) < (w_x - ONE_X);
    cond_fill = cond_oack && !done_r;
    // one send step
    len16     = (bytes_left_r < {16'd0, block_size_r}) ? bytes_left_r[15:0] : block_size_r;
    lsb_new   = lsb_r + CB'(1);
    lsb_new_x = $signed({{(SW-CB){1'b0}}, lsb_new});
    done_new  = done_r || (len16 < block_size_r);
    cont      = ((lsb_new_x - una_x) < (w_x - ONE_X)) && !done_new &&
                ((sent_r + 6'd1) < 6'(BURST_LIMIT));
    payload   = (plen_r >= 16'(HDR_BYTES)) ? plen_r - 16'(HDR_BYTES) : 16'd0;
    short_blk = {1'b0, plen_r} < ({1'b0, block_size_r} + 17'(HDR_BYTES));
    out_free  = !out_valid_r || out_ready;
  end

  assign in_ready = (state_r == S_IDLE);
  assign rd_addr  = direction_r ? lsb_slot_r : una_slot_r;
  assign wr_addr  = (lsb_r == {CB{1'b1}}) ? '0 : slot_add(lsb_slot_r, SK'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: begin
        priority if (status_r != SS_ACTIVE) state_nxt = S_IDLE;
        else if (cmd_r == OP_ERROR) state_nxt = S_EMIT;
        else if (!direction_r) begin
          priority if (cmd_r != OP_ACK) state_nxt = S_EMIT;
          else if (ack_blk == ZERO_X && oack_r) state_nxt = cond_oack ? S_SEND : S_IDLE;
          else if (ack_blk < ZERO_X) state_nxt = S_EMIT;
          else if (ack_blk == una_x - ONE_X) state_nxt = S_IDLE;
          else if (ack_blk == una_x && ack_blk > ign_x) state_nxt = S_RTT;
          else state_nxt = S_POST;
        end else begin
          priority if (cmd_r != OP_DATA) state_nxt = S_EMIT;
          else if (data_blk != lsb_x + ONE_X) state_nxt = S_IDLE;
          else if (data_blk > ign_x) state_nxt = S_RTT;
          else state_nxt = S_DACK;
        end
      end
      S_RTT:  state_nxt = direction_r ? S_DACK : S_POST;
      S_POST: state_nxt = (fin_ack || !in_win) ? S_EMIT : S_FILL;
      S_FILL: state_nxt = cond_fill ? S_SEND : S_IDLE;
      S_SEND: if (out_free) state_nxt = cont ? S_SEND : S_IDLE;
      S_DACK: if (out_free) state_nxt = short_blk ? S_EMIT : S_IDLE;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [32:0] s;
    logic [31:0] d;
    una_nxt = una_r; una_slot_nxt = una_slot_r;
    lsb_nxt = lsb_r; lsb_slot_nxt = lsb_slot_r;
    oack_nxt = oack_r; done_nxt = done_r; bytes_left_nxt = bytes_left_r;
    rtt_sum_nxt = rtt_sum_r; timed_nxt = timed_r; status_nxt = status_r;
    sent_nxt = sent_r; blk_nxt = blk_r;
    e_kind_nxt = e_kind_r; e_blk_nxt = e_blk_r; e_err_nxt = e_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r; out_blk_nxt = out_blk_r; out_bytes_nxt = out_bytes_r;
    out_err_nxt = out_err_r; out_last_nxt = out_last_r;
    out_rtt_nxt = out_rtt_r; out_timed_nxt = out_timed_r;
    wr_en = 1'b0;
    d = now_r - (rd_ok_r ? rd_data_r : 32'd0);
    s = {1'b0, rtt_sum_r} + {1'b0, d};
    unique case (state_r)
      S_EVAL: begin
        e_blk_nxt = 16'd0; e_err_nxt = 3'd0; sent_nxt = 6'd0;
        if (status_r == SS_ACTIVE) begin
          priority if (cmd_r == OP_ERROR) begin
            status_nxt = SS_PEER_ABORT; e_kind_nxt = K_ABORT;
          end else if ((!direction_r && cmd_r != OP_ACK) ||
                       (direction_r && cmd_r != OP_DATA)) begin
            status_nxt = SS_ERR_ABORT; e_kind_nxt = K_ERROR; e_err_nxt = ERR_ILLEGAL_OP;
          end else if (!direction_r) begin
            blk_nxt = ack_blk;
            e_kind_nxt = K_UNEXP; e_blk_nxt = small_r;
            if (ack_blk == ZERO_X && oack_r) oack_nxt = 1'b0;
          end else begin
            blk_nxt = data_blk;
          end
        end
      end
      S_RTT: begin
        rtt_sum_nxt = s[32] ? 32'hFFFF_FFFF : s[31:0];
        if (timed_r != 32'hFFFF_FFFF) timed_nxt = timed_r + 32'd1;
      end
      S_POST: begin
        if (fin_ack) begin
          status_nxt = SS_FINISHED; e_kind_nxt = K_DONE; e_blk_nxt = blk_r[15:0];
        end else if (in_win) begin
          una_nxt = nr[CB-1:0] + CB'(1);
          una_slot_nxt = (nr[CB-1:0] == {CB{1'b1}}) ? '0 : slot_add(una_slot_r, slide_k);
        end
      end
      S_SEND: if (out_free) begin
        wr_en = 1'b1;
        lsb_nxt = lsb_new; lsb_slot_nxt = wr_addr;
        bytes_left_nxt = bytes_left_r - {16'd0, len16};
        done_nxt = done_new; sent_nxt = sent_r + 6'd1;
        out_valid_nxt = 1'b1; out_kind_nxt = K_DATA; out_blk_nxt = lsb_new[15:0];
        out_bytes_nxt = len16; out_err_nxt = 3'd0; out_last_nxt = !cont;
        out_rtt_nxt = rtt_sum_r; out_timed_nxt = timed_r;
      end
      S_DACK: if (out_free) begin
        wr_en = 1'b1;
        lsb_nxt = lsb_new; lsb_slot_nxt = wr_addr;
        out_valid_nxt = 1'b1; out_kind_nxt = K_ACK; out_blk_nxt = lsb_new[15:0];
        out_bytes_nxt = payload; out_err_nxt = 3'd0; out_last_nxt = !short_blk;
        out_rtt_nxt = rtt_sum_r; out_timed_nxt = timed_r;
        e_kind_nxt = K_DONE; e_blk_nxt = lsb_new[15:0]; e_err_nxt = 3'd0;
        if (short_blk) status_nxt = SS_FINISHED;
      end
      S_EMIT: if (out_free) begin
        out_valid_nxt = 1'b1; out_kind_nxt = e_kind_r; out_blk_nxt = e_blk_r;
        out_bytes_nxt = 16'd0; out_err_nxt = e_err_r; out_last_nxt = 1'b1;
        out_rtt_nxt = rtt_sum_r; out_timed_nxt = timed_r;
      end
      default: ;
    endcase
    // register writes that reload session state
    if (cfg_wr_en) begin
      if (cfg_index == CFG_FILE_BYTES) bytes_left_nxt = cfg_data;
      if (cfg_index == CFG_OACK) oack_nxt = cfg_data[0];
    end
  end

  // stamp memory
  always_ff @(posedge clk) begin
    rd_data_r <= stamp_mem[rd_addr];
    if (wr_en) stamp_mem[wr_addr] <= now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_ok_r <= '0;
      rd_ok_r    <= 1'b0;
    end else begin
      rd_ok_r <= stamp_ok_r[rd_addr];
      if (wr_en) stamp_ok_r[wr_addr] <= 1'b1;
    end
  end

  // packet latch and working payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_command;
      small_r <= in_block_low;
      plen_r  <= in_packet_length;
      now_r   <= in_now_ms;
    end
    blk_r       <= blk_nxt;
    e_kind_r    <= e_kind_nxt;
    e_blk_r     <= e_blk_nxt;
    e_err_r     <= e_err_nxt;
    out_kind_r  <= out_kind_nxt;
    out_blk_r   <= out_blk_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_err_r   <= out_err_nxt;
    out_rtt_r   <= out_rtt_nxt;
    out_timed_r <= out_timed_nxt;
    out_last_r  <= out_last_nxt;
  end

  // control and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      status_r      <= SS_ACTIVE;
      out_valid_r   <= 1'b0;
      direction_r   <= 1'b0;
      window_size_r <= 6'd8;
      block_size_r  <= 16'd512;
      rtt_ign_r     <= 32'd0;
      una_r         <= CB'(1);
      una_slot_r    <= UNA_SLOT0;
      lsb_r         <= '0;
      lsb_slot_r    <= '0;
      oack_r        <= 1'b0;
      done_r        <= 1'b0;
      bytes_left_r  <= 32'd0;
      rtt_sum_r     <= 32'd0;
      timed_r       <= 32'd0;
      sent_r        <= 6'd0;
    end else begin
      state_r      <= state_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
      una_r        <= una_nxt;
      una_slot_r   <= una_slot_nxt;
      lsb_r        <= lsb_nxt;
      lsb_slot_r   <= lsb_slot_nxt;
      oack_r       <= oack_nxt;
      done_r       <= done_nxt;
      bytes_left_r <= bytes_left_nxt;
      rtt_sum_r    <= rtt_sum_nxt;
      timed_r      <= timed_nxt;
      sent_r       <= sent_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DIRECTION:  direction_r   <= cfg_data[0];
          CFG_WINDOW:     window_size_r <= cfg_data[5:0];
          CFG_BLOCK_SIZE: block_size_r  <= cfg_data[15:0];
          CFG_RTT_IGNORE: rtt_ign_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_block_number  = out_blk_r;
  assign out_byte_count    = out_bytes_r;
  assign out_error_code    = out_err_r;
  assign out_rtt_total     = out_rtt_r;
  assign out_timed_packets = out_timed_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  // a packet taken after the session ended causes no work
  a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && status_r != SS_ACTIVE) |=> state_r == S_IDLE)
    else $error("ended session did not return to idle");

  // ring slots stay inside the memory
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(una_slot_r) < 32'(WINDOW_MAX)) && (32'(lsb_slot_r) < 32'(WINDOW_MAX)))
    else $error("stamp slot out of range");

  // a finished result always closes its packet
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == K_DONE) |-> out_last_r)
    else $error("finished result not marked last");
`endif

endmodule
